@@ design/dwws_pkg.sv @@
// Shared types and constants of the deferred write window scheduler.
package dwws_pkg;

  localparam int SECOND_MS      = 1000;
  localparam int TWO_SECONDS_MS = 2 * SECOND_MS;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_DECIDE  = 2'd1,
    OP_PLACED  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    V_IDLE   = 2'd0,
    V_HOLD   = 2'd1,
    V_PLACE  = 2'd2,
    V_FORCED = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    REG_JITTER_GUARD = 3'd0,
    REG_DIRECT_START = 3'd1,
    REG_VIEW_STALE   = 3'd2,
    REG_WORST_WRITE  = 3'd3,
    REG_MAX_DEFER    = 3'd4,
    REG_SETTLE       = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  jitter_guard_ms;
    logic [10:0] direct_start_ms;
    logic [15:0] view_stale_ms;
    logic [9:0]  worst_write_ms;
    logic [31:0] max_defer_ms;
    logic [31:0] settle_ms;
  } cfg_t;

endpackage

@@ design/dwws_window.sv @@
// Dwell window check: decides whether a worst-case write fits the current dwell.
module dwws_window (
  input  dwws_pkg::cfg_t      cfg,
  input  logic [31:0]         now_ms,
  input  logic                may_transmit,
  input  logic [10:0]         plan_start_ms,
  input  logic [10:0]         plan_end_ms,
  input  logic                dwell_armed,
  input  logic                burst_unreported,
  input  logic [31:0]         view_time_ms,
  input  logic signed [11:0]  view_phase_ms,
  output logic                placeable
);

  localparam logic [17:0] SEC18  = 18'(dwws_pkg::SECOND_MS);
  localparam logic [18:0] SEC19  = 19'(dwws_pkg::SECOND_MS);
  localparam logic [18:0] TWO19  = 19'(dwws_pkg::TWO_SECONDS_MS);
  localparam logic [10:0] SEC11  = 11'(dwws_pkg::SECOND_MS);

  logic [31:0]        age;
  logic               stale;
  logic signed [18:0] phase;
  logic [17:0]        ph_fold;
  logic [17:0]        at;
  logic [18:0]        fin;
  logic [10:0]        wrap_lim;
  logic               wraps;
  logic [18:0]        edge_ms;
  logic               refused;

  always_comb begin
    age   = now_ms - view_time_ms;
    stale = age > {16'd0, cfg.view_stale_ms};
    // When the view is fresh the age fits in 17 bits, so the phase fits in 19 signed bits.
    phase = 19'(view_phase_ms) + $signed({2'b00, age[16:0]});
    ph_fold = (phase[17:0] >= SEC18) ? (phase[17:0] - SEC18) : phase[17:0];
    wrap_lim = plan_end_ms - SEC11;
    wraps = (plan_end_ms > SEC11) && (ph_fold < {7'd0, wrap_lim});
    at = wraps ? (ph_fold + SEC18) : ph_fold;
    fin = {1'b0, at} + 19'(cfg.worst_write_ms) + 19'(cfg.jitter_guard_ms);
    edge_ms = (at < SEC18) ? SEC19 : TWO19;
    refused = (at < {7'd0, plan_start_ms})
           || (fin > {8'd0, plan_end_ms})
           || ((at < {7'd0, cfg.direct_start_ms}) && (fin > {8'd0, cfg.direct_start_ms}))
           || (fin > edge_ms);
    placeable = !dwell_armed
             || (!burst_unreported && !stale && !may_transmit && !phase[18] && !refused);
  end

endmodule

@@ design/deferred_write_window_scheduler_unit.sv @@
// Top level of the deferred write window scheduler with its register file.
//
// Usage: firmware events enter on the in_ channel (valid/ready). Opcode request
// marks a write pending, decide asks for a verdict (idle, hold, place, forced)
// and placed reports that the write ran. Every item yields exactly one result
// on the out_ channel carrying the verdict, the pending flag, the request,
// write and forced totals and the longest wait seen so far.
// The item is captured in an input register, evaluated by short logic and the
// result is registered, so out_valid rises once the result register has taken
// it, and a new item can be taken every cycle while out_ready stays high, since
// the result register then frees each time the input register advances.
// When the receiver stalls the result register holds; the input register takes
// one more item only if it is empty, then in_ready stays low until out_ready returns.
// Settings are written over the APB port (psel/penable/pwrite, pready always
// high) and read back at the same addresses, four bytes apart.
// Reset (rst_n low, synchronous) empties both registers, clears the pending
// write, the counters and the longest wait, and loads the default settings.
module deferred_write_window_scheduler_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [31:0]                   in_now_ms,
  input  logic                          in_may_transmit,
  input  logic [10:0]                   in_plan_start_ms,
  input  logic [10:0]                   in_plan_end_ms,
  input  logic                          in_dwell_armed,
  input  logic                          in_burst_unreported,
  input  logic [31:0]                   in_view_time_ms,
  input  logic signed [11:0]            in_view_phase_ms,
  input  logic                          in_placed_forced,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_verdict,
  output logic                          out_is_pending,
  output logic [31:0]                   out_request_count,
  output logic [31:0]                   out_write_count,
  output logic [31:0]                   out_forced_count,
  output logic [31:0]                   out_worst_wait_ms,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dwws_pkg::PADDR_W-1:0]  paddr,
  input  logic [dwws_pkg::PDATA_W-1:0]  pwdata,
  output logic [dwws_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  // Configuration registers.
  dwws_pkg::cfg_t cfg_r;
  dwws_pkg::cfg_t cfg_nxt;
  logic [2:0]     reg_idx;
  logic           cfg_wr;

  // Input register.
  logic               in_valid_r;
  logic [1:0]         opcode_r;
  logic [31:0]        now_r;
  logic               may_transmit_r;
  logic [10:0]        plan_start_r;
  logic [10:0]        plan_end_r;
  logic               dwell_armed_r;
  logic               burst_unreported_r;
  logic [31:0]        view_time_r;
  logic signed [11:0] view_phase_r;
  logic               placed_forced_r;

  // Scheduler state and result register.
  logic        out_valid_r;
  logic [1:0]  verdict_r;
  logic [1:0]  verdict_nxt;
  logic        pending_r;
  logic        pending_nxt;
  logic [31:0] first_r;
  logic [31:0] first_nxt;
  logic [31:0] last_r;
  logic [31:0] last_nxt;
  logic [31:0] req_cnt_r;
  logic [31:0] req_cnt_nxt;
  logic [31:0] wr_cnt_r;
  logic [31:0] wr_cnt_nxt;
  logic [31:0] forced_cnt_r;
  logic [31:0] forced_cnt_nxt;
  logic [31:0] worst_r;
  logic [31:0] worst_nxt;

  logic        advance;
  logic        fire;
  logic        placeable;
  logic [31:0] since_first;
  logic        spent;
  logic        settling;

  assign pready  = 1'b1;
  assign reg_idx = paddr[dwws_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        dwws_pkg::REG_JITTER_GUARD: cfg_nxt.jitter_guard_ms = pwdata[7:0];
        dwws_pkg::REG_DIRECT_START: cfg_nxt.direct_start_ms = pwdata[10:0];
        dwws_pkg::REG_VIEW_STALE:   cfg_nxt.view_stale_ms   = pwdata[15:0];
        dwws_pkg::REG_WORST_WRITE:  cfg_nxt.worst_write_ms  = pwdata[9:0];
        dwws_pkg::REG_MAX_DEFER:    cfg_nxt.max_defer_ms    = pwdata;
        dwws_pkg::REG_SETTLE:       cfg_nxt.settle_ms       = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dwws_pkg::REG_JITTER_GUARD: prdata = {24'd0, cfg_r.jitter_guard_ms};
      dwws_pkg::REG_DIRECT_START: prdata = {21'd0, cfg_r.direct_start_ms};
      dwws_pkg::REG_VIEW_STALE:   prdata = {16'd0, cfg_r.view_stale_ms};
      dwws_pkg::REG_WORST_WRITE:  prdata = {22'd0, cfg_r.worst_write_ms};
      dwws_pkg::REG_MAX_DEFER:    prdata = cfg_r.max_defer_ms;
      dwws_pkg::REG_SETTLE:       prdata = cfg_r.settle_ms;
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jitter_guard_ms <= 8'd2;
      cfg_r.direct_start_ms <= 11'd450;
      cfg_r.view_stale_ms   <= 16'd50;
      cfg_r.worst_write_ms  <= 10'd20;
      cfg_r.max_defer_ms    <= 32'd2000;
      cfg_r.settle_ms       <= 32'd500;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The result register frees when it is empty or taken; the input register also when it is empty.
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || advance;
  assign fire      = in_valid_r && advance;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      opcode_r           <= in_opcode;
      now_r              <= in_now_ms;
      may_transmit_r     <= in_may_transmit;
      plan_start_r       <= in_plan_start_ms;
      plan_end_r         <= in_plan_end_ms;
      dwell_armed_r      <= in_dwell_armed;
      burst_unreported_r <= in_burst_unreported;
      view_time_r        <= in_view_time_ms;
      view_phase_r       <= in_view_phase_ms;
      placed_forced_r    <= in_placed_forced;
    end
  end

  dwws_window u_window (
    .cfg              (cfg_r),
    .now_ms           (now_r),
    .may_transmit     (may_transmit_r),
    .plan_start_ms    (plan_start_r),
    .plan_end_ms      (plan_end_r),
    .dwell_armed      (dwell_armed_r),
    .burst_unreported (burst_unreported_r),
    .view_time_ms     (view_time_r),
    .view_phase_ms    (view_phase_r),
    .placeable        (placeable)
  );

  always_comb begin
    since_first    = now_r - first_r;
    spent          = since_first >= cfg_r.max_defer_ms;
    settling       = (now_r - last_r) < cfg_r.settle_ms;
    verdict_nxt    = dwws_pkg::V_IDLE;
    pending_nxt    = pending_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    req_cnt_nxt    = req_cnt_r;
    wr_cnt_nxt     = wr_cnt_r;
    forced_cnt_nxt = forced_cnt_r;
    worst_nxt      = worst_r;
    unique case (opcode_r)
      dwws_pkg::OP_REQUEST: begin
        req_cnt_nxt = req_cnt_r + 32'd1;
        pending_nxt = 1'b1;
        last_nxt    = now_r;
        if (!pending_r) begin
          first_nxt = now_r;
        end
      end
      dwws_pkg::OP_DECIDE: begin
        if (pending_r) begin
          if (!spent && settling) begin
            verdict_nxt = dwws_pkg::V_HOLD;
          end else if (placeable) begin
            verdict_nxt = dwws_pkg::V_PLACE;
          end else if (spent) begin
            verdict_nxt = dwws_pkg::V_FORCED;
          end else begin
            verdict_nxt = dwws_pkg::V_HOLD;
          end
        end
      end
      dwws_pkg::OP_PLACED: begin
        // The wait is taken from the stored first time even if nothing was pending.
        if (since_first > worst_r) begin
          worst_nxt = since_first;
        end
        wr_cnt_nxt  = wr_cnt_r + 32'd1;
        pending_nxt = 1'b0;
        if (placed_forced_r) begin
          forced_cnt_nxt = forced_cnt_r + 32'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      verdict_r    <= dwws_pkg::V_IDLE;
      pending_r    <= 1'b0;
      first_r      <= '0;
      last_r       <= '0;
      req_cnt_r    <= '0;
      wr_cnt_r     <= '0;
      forced_cnt_r <= '0;
      worst_r      <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        verdict_r    <= verdict_nxt;
        pending_r    <= pending_nxt;
        first_r      <= first_nxt;
        last_r       <= last_nxt;
        req_cnt_r    <= req_cnt_nxt;
        wr_cnt_r     <= wr_cnt_nxt;
        forced_cnt_r <= forced_cnt_nxt;
        worst_r      <= worst_nxt;
      end
    end
  end

  // State changes only together with a new result, so it doubles as the result payload.
  assign out_verdict       = verdict_r;
  assign out_is_pending    = pending_r;
  assign out_request_count = req_cnt_r;
  assign out_write_count   = wr_cnt_r;
  assign out_forced_count  = forced_cnt_r;
  assign out_worst_wait_ms = worst_r;

endmodule
